>>> sv/sibic_pkg.sv
package sibic_pkg;

    localparam int MAX_LEN  = 64;
    localparam int MAX_SEQS = 64;

    localparam int SYM_W   = 8;
    localparam int KEY_W   = 11;
    localparam int IDX_W   = 6;
    localparam int SA_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int KA_W    = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEQS + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             eos;
        logic             eset;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] seq_index;
        logic [KEY_W-1:0] inversions;
        logic             last;
        logic             overflow;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_STORE,
        ST_CLOSE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

>>> sv/stable_sort_by_inversion_count_core.sv
// stream block that counts inversions of byte sequences and returns the sequence indices
// sorted by count, ties in arrival order. one beat per symbol; tuser marks the end of a
// sequence, tlast the end of the set (which also ends the sequence). each symbol is compared
// with the symbols already held in its sequence, one per cycle through the single read port
// of the symbol memory, and then stored; closing a sequence writes its count to the key memory.
// at end of set each result is found by a selection scan over the key memory.
// a four-deep queue lets the input keep streaming while the engine works, and the
// result register lets the engine move on while a result waits to be taken.
// symbols past 64 in a sequence or sequences past 64 in a set are dropped and flagged.
module stable_sort_by_inversion_count_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
    input  logic        s_axis_tlast,   // end_of_set
    input  logic        s_axis_tuser,   // end_of_sequence
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // seq_index[5:0], inversions[16:6], zero pad
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser    // overflow
);

    sibic_pkg::t_item   w_in_item;
    sibic_pkg::t_item   w_q_item;
    sibic_pkg::t_result w_res;
    logic               w_avail;
    logic               w_pop;

    assign w_in_item.symbol = s_axis_tdata;
    assign w_in_item.eos    = s_axis_tuser;
    assign w_in_item.eset   = s_axis_tlast;

    // front: input queue
    sibic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_avail (w_avail),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    // back: inversion counting and sorted emission
    sibic_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .o_pop    (w_pop),
        .i_item   (w_q_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.inversions, w_res.seq_index};
    assign m_axis_tlast = w_res.last;
    assign m_axis_tuser = w_res.overflow;

endmodule

>>> sv/sibic_front.sv
module sibic_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sibic_pkg::t_item i_item,
    output logic             o_avail,
    input  logic             i_pop,
    output sibic_pkg::t_item o_item
);

    sibic_pkg::t_item r_mem [sibic_pkg::Q_DEPTH];
    logic [sibic_pkg::Q_AW-1:0] r_wr_ptr;
    logic [sibic_pkg::Q_AW-1:0] r_rd_ptr;
    logic [sibic_pkg::Q_AW:0]   r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_ready = (r_count != (sibic_pkg::Q_AW+1)'(sibic_pkg::Q_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

>>> sv/sibic_back.sv
module sibic_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    output logic               o_pop,
    input  sibic_pkg::t_item   i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sibic_pkg::t_result o_result
);

    localparam logic [sibic_pkg::CNT_W-1:0] SEQ_LIM = sibic_pkg::CNT_W'(sibic_pkg::MAX_SEQS);
    localparam logic [sibic_pkg::POS_W-1:0] LEN_LIM = sibic_pkg::POS_W'(sibic_pkg::MAX_LEN);

    sibic_pkg::t_state r_state, n_state;
    sibic_pkg::t_item  r_item;

    logic [sibic_pkg::SYM_W-1:0] r_sym_mem [sibic_pkg::MAX_LEN];
    logic [sibic_pkg::KEY_W-1:0] r_key_mem [sibic_pkg::MAX_SEQS];

    logic [sibic_pkg::POS_W-1:0] r_pos;
    logic [sibic_pkg::CNT_W-1:0] r_seq_cnt;
    logic [sibic_pkg::KEY_W-1:0] r_run;
    logic                        r_ovf;
    logic [sibic_pkg::POS_W-1:0] r_idx;
    logic [sibic_pkg::POS_W-1:0] r_greater;
    logic [sibic_pkg::SYM_W-1:0] r_sym_q;
    logic [sibic_pkg::CNT_W-1:0] r_kidx;
    logic [sibic_pkg::KEY_W-1:0] r_key_q;
    logic [sibic_pkg::KA_W-1:0]  r_kq_idx;
    logic                        r_qv;
    logic [sibic_pkg::CNT_W-1:0] r_slot;
    logic                        r_first;
    logic [sibic_pkg::KEY_W-1:0] r_pk;
    logic [sibic_pkg::KA_W-1:0]  r_pj;
    logic                        r_have;
    logic [sibic_pkg::KEY_W-1:0] r_bk;
    logic [sibic_pkg::KA_W-1:0]  r_bj;
    logic                        r_out_valid;
    sibic_pkg::t_result          r_out;

    logic                        w_can_load;
    logic                        w_last;
    logic                        w_cand;
    logic                        w_seq_room;
    logic [sibic_pkg::KEY_W:0]   w_sum;

    assign w_can_load = !r_out_valid || i_ready;
    assign w_last     = (r_slot == r_seq_cnt - 1'b1);
    assign w_seq_room = (r_seq_cnt < SEQ_LIM);
    assign w_sum      = {1'b0, r_run} + (sibic_pkg::KEY_W+1)'(r_greater);
    // later in (key, index) order than the last emitted, lowest key seen so far (earliest on a tie)
    assign w_cand = (r_first || (r_key_q > r_pk) || ((r_key_q == r_pk) && (r_kq_idx > r_pj)))
                    && (!r_have || (r_key_q < r_bk));
    assign o_pop    = (r_state == sibic_pkg::ST_IDLE) && i_avail;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sibic_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sibic_pkg::ST_IDLE: begin
                if (i_avail) begin
                    if (w_seq_room && (r_pos < LEN_LIM))
                        n_state = (r_pos == '0) ? sibic_pkg::ST_STORE : sibic_pkg::ST_CMP;
                    else if (i_item.eos || i_item.eset)
                        n_state = sibic_pkg::ST_CLOSE;
                end
            end
            sibic_pkg::ST_CMP: begin
                if ((r_idx == r_pos) && !r_qv) n_state = sibic_pkg::ST_STORE;
            end
            sibic_pkg::ST_STORE: begin
                n_state = (r_item.eos || r_item.eset) ? sibic_pkg::ST_CLOSE
                                                      : sibic_pkg::ST_IDLE;
            end
            sibic_pkg::ST_CLOSE: begin
                n_state = r_item.eset ? sibic_pkg::ST_SCAN : sibic_pkg::ST_IDLE;
            end
            sibic_pkg::ST_SCAN: begin
                if ((r_kidx == r_seq_cnt) && !r_qv) n_state = sibic_pkg::ST_EMIT;
            end
            sibic_pkg::ST_EMIT: begin
                if (w_can_load) n_state = w_last ? sibic_pkg::ST_IDLE : sibic_pkg::ST_SCAN;
            end
            default: n_state = sibic_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sym_q  <= r_sym_mem[r_idx[sibic_pkg::SA_W-1:0]];
        r_key_q  <= r_key_mem[r_kidx[sibic_pkg::KA_W-1:0]];
        r_kq_idx <= r_kidx[sibic_pkg::KA_W-1:0];
        if (r_state == sibic_pkg::ST_STORE)
            r_sym_mem[r_pos[sibic_pkg::SA_W-1:0]] <= r_item.symbol;
        if ((r_state == sibic_pkg::ST_CLOSE) && w_seq_room)
            r_key_mem[r_seq_cnt[sibic_pkg::KA_W-1:0]] <= r_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seq_cnt   <= '0;
            r_run       <= '0;
            r_ovf       <= 1'b0;
            r_qv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_can_load && !(r_state == sibic_pkg::ST_EMIT)) r_out_valid <= 1'b0;
            unique case (r_state)
                sibic_pkg::ST_IDLE: begin
                    if (i_avail) begin
                        r_item    <= i_item;
                        r_idx     <= '0;
                        r_qv      <= 1'b0;
                        r_greater <= '0;
                        if (w_seq_room && !(r_pos < LEN_LIM)) r_ovf <= 1'b1;
                    end
                end
                sibic_pkg::ST_CMP: begin
                    if (r_idx < r_pos) begin
                        r_idx <= r_idx + 1'b1;
                        r_qv  <= 1'b1;
                    end else begin
                        r_qv  <= 1'b0;
                    end
                    if (r_qv && (r_sym_q > r_item.symbol)) r_greater <= r_greater + 1'b1;
                end
                sibic_pkg::ST_STORE: begin
                    r_run <= (w_sum > {1'b0, sibic_pkg::KEY_MAX}) ? sibic_pkg::KEY_MAX
                                                               : w_sum[sibic_pkg::KEY_W-1:0];
                    r_pos <= r_pos + 1'b1;
                end
                sibic_pkg::ST_CLOSE: begin
                    if (w_seq_room) r_seq_cnt <= r_seq_cnt + 1'b1;
                    else            r_ovf     <= 1'b1;
                    r_pos   <= '0;
                    r_run   <= '0;
                    r_slot  <= '0;
                    r_first <= 1'b1;
                    r_kidx  <= '0;
                    r_qv    <= 1'b0;
                    r_have  <= 1'b0;
                end
                sibic_pkg::ST_SCAN: begin
                    if (r_kidx < r_seq_cnt) begin
                        r_kidx <= r_kidx + 1'b1;
                        r_qv   <= 1'b1;
                    end else begin
                        r_qv   <= 1'b0;
                    end
                    if (r_qv && w_cand) begin
                        r_have <= 1'b1;
                        r_bk   <= r_key_q;
                        r_bj   <= r_kq_idx;
                    end
                end
                sibic_pkg::ST_EMIT: begin
                    if (w_can_load) begin
                        r_out_valid         <= 1'b1;
                        r_out.seq_index     <= sibic_pkg::IDX_W'(r_bj);
                        r_out.inversions    <= r_bk;
                        r_out.last          <= w_last;
                        r_out.overflow      <= r_ovf;
                        r_pk                <= r_bk;
                        r_pj                <= r_bj;
                        r_first             <= 1'b0;
                        r_slot              <= r_slot + 1'b1;
                        r_kidx              <= '0;
                        r_qv                <= 1'b0;
                        r_have              <= 1'b0;
                        if (w_last) begin
                            r_seq_cnt <= '0;
                            r_ovf     <= 1'b0;
                        end
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_qv <= 1'b0;
            endcase
        end
    end

endmodule

>>> tb/stable_sort_by_inversion_count_core_tb.sv
module stable_sort_by_inversion_count_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
    localparam int LONG_HOLD   = 400;   // receiver hold-off while sender keeps going

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // symbol[7:0]
    logic        s_axis_tlast;    // end_of_set
    logic        s_axis_tuser;    // end_of_sequence
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // seq_index[5:0], inversions[16:6], zero pad
    logic        m_axis_tlast;    // last
    logic        m_axis_tuser;    // overflow

    stable_sort_by_inversion_count_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // directed rows; a typed expectation only where it is obvious
    typedef struct {
        logic [7:0]                  symbol;
        logic                        eos;
        logic                        eset;
        bit                          typed;
        logic [sibic_pkg::IDX_W-1:0] exp_idx;
        logic [sibic_pkg::KEY_W-1:0] exp_inv;
    } t_row;

    // predictor state
    logic [sibic_pkg::SYM_W-1:0] held_symbols [sibic_pkg::MAX_LEN];
    logic [sibic_pkg::KEY_W-1:0] seq_keys     [sibic_pkg::MAX_SEQS];
    int               held_len;
    int               seqs_done;
    int               inv_so_far;
    bit               dropped;

    sibic_pkg::t_result sorted_q [$];   // results still owed by the block

    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  sets_sent;
    int  quiet_cycles;
    bit  idle_on;
    bit  hold_req;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // fold one accepted beat into the predictor, queue any results it releases
    task automatic predict_beat(input logic [7:0] sym, input logic eos, input logic eset,
                                input bit typed, input logic [sibic_pkg::IDX_W-1:0] t_idx,
                                input logic [sibic_pkg::KEY_W-1:0] t_inv);
        int                 order [sibic_pkg::MAX_SEQS];
        int                 cur;
        int                 b;
        int                 greater;
        sibic_pkg::t_result r;
        greater = 0;
        // symbols of a sequence that will be dropped at its end are ignored
        if (seqs_done < sibic_pkg::MAX_SEQS) begin
            if (held_len >= sibic_pkg::MAX_LEN) begin
                dropped = 1'b1;
            end else begin
                for (int p = 0; p < held_len; p++)
                    if (held_symbols[p] > sym) greater++;
                inv_so_far += greater;
                if (inv_so_far > int'(sibic_pkg::KEY_MAX)) inv_so_far = int'(sibic_pkg::KEY_MAX);
                held_symbols[held_len] = sym;
                held_len++;
            end
        end
        if (eos || eset) begin
            if (seqs_done < sibic_pkg::MAX_SEQS) begin
                seq_keys[seqs_done] = inv_so_far[sibic_pkg::KEY_W-1:0];
                seqs_done++;
            end else begin
                dropped = 1'b1;
            end
            held_len   = 0;
            inv_so_far = 0;
        end
        if (eset) begin
            for (int a = 0; a < seqs_done; a++) order[a] = a;
            // stable insertion sort on the key
            for (int a = 1; a < seqs_done; a++) begin
                cur = order[a];
                b   = a;
                while (b > 0 && seq_keys[order[b-1]] > seq_keys[cur]) begin
                    order[b] = order[b-1];
                    b--;
                end
                order[b] = cur;
            end
            for (int a = 0; a < seqs_done; a++) begin
                r.seq_index  = order[a][sibic_pkg::IDX_W-1:0];
                r.inversions = seq_keys[order[a]];
                r.last       = (a + 1 == seqs_done);
                r.overflow   = dropped;
                if (typed) begin
                    r.seq_index  = t_idx;
                    r.inversions = t_inv;
                end
                sorted_q.push_back(r);
            end
            seqs_done = 0;
            dropped   = 1'b0;
            sets_sent++;
        end
    endtask

    // offer one beat, keeping tvalid high across back-to-back beats
    task automatic send_beat(input logic [7:0] sym, input logic eos, input logic eset,
                             input bit typed = 0,
                             input logic [sibic_pkg::IDX_W-1:0] t_idx = '0,
                             input logic [sibic_pkg::KEY_W-1:0] t_inv = '0);
        while (idle_on && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= eos;
        s_axis_tlast  <= eset;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_beat(sym, eos, eset, typed, t_idx, t_inv);
        items_sent++;
    endtask

    // one sequence of random content; the final beat may also close the set
    task automatic send_sequence(input int len, input bit close_set);
        for (int k = 0; k < len; k++)
            send_beat(8'($urandom_range(255)), (k == len - 1) && (close_set ? $urandom_range(1)
                      : 1'b1), close_set && (k == len - 1));
    endtask

    // receiver: check every result beat, stall at random or for a long hold
    always @(posedge i_clk) begin
        sibic_pkg::t_result got;
        sibic_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.seq_index  = m_axis_tdata[5:0];
            got.inversions = m_axis_tdata[16:6];
            got.last       = m_axis_tlast;
            got.overflow   = m_axis_tuser;
            results_seen++;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: idx %0d inv %0d last %0b ovf %0b",
                             got.seq_index, got.inversions, got.last, got.overflow);
            end else begin
                want = sorted_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp idx %0d inv %0d last %0b ovf %0b,",
                                  " got idx %0d inv %0d last %0b ovf %0b"},
                                 want.seq_index, want.inversions, want.last, want.overflow,
                                 got.seq_index, got.inversions, got.last, got.overflow);
                end
            end
        end
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 6);
        end
    end

    // watchdog on cycles with no beat at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results owed",
                     quiet_cycles, sorted_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        int   n_seq;
        int   base_sets;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        idle_on       = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        quiet_cycles  = 0;
        mismatches    = 0;
        items_sent    = 0;
        results_seen  = 0;
        sets_sent     = 0;
        held_len      = 0;
        seqs_done     = 0;
        inv_so_far    = 0;
        dropped       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        rows = '{
            // single zero symbol as a whole set
            '{8'h00, 1'b1, 1'b1, 1, 6'd0, 11'd0},
            // end of set without end of sequence
            '{8'hff, 1'b0, 1'b1, 1, 6'd0, 11'd0},
            // one inversion: 255 then 0
            '{8'hff, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h00, 1'b0, 1'b1, 1, 6'd0, 11'd1},
            // equal symbols are no inversion
            '{8'h80, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h80, 1'b0, 1'b1, 1, 6'd0, 11'd0},
            // four sequences with a reversal, checked by prediction
            '{8'h55, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'haa, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h01, 1'b1, 1'b0, 0, 6'd0, 11'd0},
            '{8'h03, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h02, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h01, 1'b1, 1'b0, 0, 6'd0, 11'd0},
            '{8'h10, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h20, 1'b1, 1'b0, 0, 6'd0, 11'd0},
            '{8'h7f, 1'b0, 1'b0, 0, 6'd0, 11'd0},
            '{8'h00, 1'b0, 1'b1, 0, 6'd0, 11'd0}
        };
        foreach (rows[i])
            send_beat(rows[i].symbol, rows[i].eos, rows[i].eset,
                      rows[i].typed, rows[i].exp_idx, rows[i].exp_inv);

        // long sequence, strictly falling, past the symbol limit; a long stretch
        // with no idling on either side
        for (int k = 0; k < sibic_pkg::MAX_LEN + 6; k++)
            send_beat(8'(250 - 3 * k), 1'b0, k == sibic_pkg::MAX_LEN + 5);

        idle_on = 1'b1;

        // too many sequences in one set
        for (int k = 0; k < sibic_pkg::MAX_SEQS + 2; k++)
            send_beat(8'($urandom_range(255)), 1'b1, k == sibic_pkg::MAX_SEQS + 1);

        // sender pauses until the block has drained
        s_axis_tvalid <= 1'b0;
        wait (sorted_q.size() == 0);
        @(posedge i_clk);

        // random small sets with a long receiver hold-off on the first one
        base_sets = sets_sent;
        while (items_sent < 180) begin
            if (sets_sent == base_sets) hold_req = 1'b1;
            n_seq = $urandom_range(1, 3);
            for (int q = 0; q < n_seq; q++)
                send_sequence($urandom_range(1, 4), q == n_seq - 1);
        end

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        wait (sorted_q.size() == 0);
        repeat (300) @(posedge i_clk);

        $display("%0d symbol beats in %0d sets, %0d sorted results checked, %0d mismatches",
                 items_sent, sets_sent, results_seen, mismatches);
        $display("covered overlong sequence, excess sequences, ties, long output hold-off");
        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/sibic_pkg.sv
sv/sibic_front.sv
sv/sibic_back.sv
sv/stable_sort_by_inversion_count_core.sv
tb/stable_sort_by_inversion_count_core_tb.sv
